>>> src/atcp_pkg.sv
// Shared types and constants for the ANSI text console parser.
`timescale 1ns / 1ps

package atcp_pkg;

  // display command codes
  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_SCROLL = 2'd1;
  localparam logic [1:0] CMD_ERASE  = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 2'd2;

  // result packing: command, column, line, glyph, fg_index, bg_index
  localparam int unsigned OUT_W = 40;

  localparam logic [3:0] FG_DEFAULT = 4'd7;
  localparam logic [3:0] FG_GRAY    = 4'd8;
  localparam logic [2:0] BG_DEFAULT = 3'd0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CR,
    OP_LF,
    OP_BS,
    OP_DRAW,
    OP_ERASE,
    OP_SCROLL,
    OP_ESC_CLR,
    OP_DIGIT,
    OP_SEMI,
    OP_SGR_STEP,
    OP_CLEAR,
    OP_CUP,
    OP_CUU,
    OP_CUD
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       enabled;
    logic       out_free;
    logic       draw_scroll;
    logic       p0_is2;
    logic       sgr_last;
  } dp_stat_t;

endpackage

>>> src/ansi_text_console_parser.sv
// ANSI text console parser top level: controller plus datapath.
`timescale 1ns / 1ps
//
// Byte stream in on s_tvalid/s_tready/s_tdata, one character per transaction.
// Display commands out on m_tvalid/m_tready/m_tdata/m_tlast; m_tlast marks the
// final command caused by one input byte (at most two: a draw then a scroll).
// Configuration via cfg_we/cfg_index/cfg_data: 0 enabled, 1 columns, 2 rows.
// One byte is worked on at a time; the next byte is accepted only once the
// last is done, and an SGR final also walks the stored parameters through
// the datapath in turn. The first command is registered from the execute
// state; an erase goes through the erase state and a clear through the
// final-byte state first. A stalled receiver holds the output register; the
// block waits when it has a new command to place there and on a line feed.
// Reset (synchronous, rst high) restores the register defaults, homes the
// cursor, sets white on black and leaves the output empty; s_tready is high
// directly after reset.
//
module ansi_text_console_parser #(
  parameter int unsigned MAX_PARAMS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // char_byte[7:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // command[1:0], column[9:2], line[17:10], glyph[25:18], fg_index[29:26],
  // bg_index[32:30], zero[39:33]
  output logic [atcp_pkg::OUT_W-1:0]      m_tdata,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [atcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atcp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import atcp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  atcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  atcp_dp #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> src/atcp_ctrl.sv
// Controller: escape-parser state and per-byte operation sequencing.
`timescale 1ns / 1ps

module atcp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  atcp_pkg::dp_stat_t stat,
  output atcp_pkg::dp_cmd_t  cmd
);
  import atcp_pkg::*;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_SGR   = 8'h6D;
  localparam logic [7:0] CH_ED    = 8'h4A;
  localparam logic [7:0] CH_CUP   = 8'h48;
  localparam logic [7:0] CH_HVP   = 8'h66;
  localparam logic [7:0] CH_CUU   = 8'h41;
  localparam logic [7:0] CH_CUD   = 8'h42;

  typedef enum logic [2:0] {
    C_IDLE,
    C_EXEC,
    C_FINAL,
    C_SGR,
    C_ERASE,
    C_SCROLL
  } state_t;

  typedef enum logic [1:0] {
    P_NORMAL,
    P_ESC,
    P_SEQ
  } parse_t;

  state_t     state, state_next;
  parse_t     parse, parse_next;
  logic [7:0] ch;

  assign ch = stat.char_code;

  always_comb begin
    state_next = state;
    parse_next = parse;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      C_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = C_EXEC;
        end
      end
      C_EXEC: begin
        if (!stat.enabled) begin
          state_next = C_IDLE;
        end else begin
          unique case (parse)
            P_NORMAL: begin
              priority if (ch == CH_ESC) begin
                parse_next = P_ESC;
                state_next = C_IDLE;
              end else if (ch == CH_CR) begin
                cmd.op     = OP_CR;
                state_next = C_IDLE;
              end else if (ch == CH_LF) begin
                if (stat.out_free) begin
                  cmd.op     = OP_LF;
                  state_next = C_IDLE;
                end
              end else if (ch == CH_BS || ch == CH_DEL) begin
                cmd.op     = OP_BS;
                state_next = C_ERASE;
              end else if (ch >= CH_SPACE && ch < CH_DEL) begin
                if (stat.out_free) begin
                  cmd.op     = OP_DRAW;
                  state_next = stat.draw_scroll ? C_SCROLL : C_IDLE;
                end
              end else begin
                state_next = C_IDLE;
              end
            end
            P_ESC: begin
              if (ch == CH_LBR) begin
                cmd.op     = OP_ESC_CLR;
                parse_next = P_SEQ;
              end else begin
                parse_next = P_NORMAL;
              end
              state_next = C_IDLE;
            end
            P_SEQ: begin
              priority if (ch >= CH_ZERO && ch <= CH_NINE) begin
                cmd.op     = OP_DIGIT;
                state_next = C_IDLE;
              end else if (ch == CH_SEMI) begin
                cmd.op     = OP_SEMI;
                state_next = C_IDLE;
              end else begin
                // final byte: store the pending parameter first
                cmd.op     = OP_SEMI;
                parse_next = P_NORMAL;
                state_next = C_FINAL;
              end
            end
            default: begin
              parse_next = P_NORMAL;
              state_next = C_IDLE;
            end
          endcase
        end
      end
      C_FINAL: begin
        priority if (ch == CH_SGR) begin
          state_next = C_SGR;
        end else if (ch == CH_ED) begin
          if (!stat.p0_is2) begin
            state_next = C_IDLE;
          end else if (stat.out_free) begin
            cmd.op     = OP_CLEAR;
            state_next = C_IDLE;
          end
        end else if (ch == CH_CUP || ch == CH_HVP) begin
          cmd.op     = OP_CUP;
          state_next = C_IDLE;
        end else if (ch == CH_CUU) begin
          cmd.op     = OP_CUU;
          state_next = C_IDLE;
        end else if (ch == CH_CUD) begin
          cmd.op     = OP_CUD;
          state_next = C_IDLE;
        end else begin
          state_next = C_IDLE;
        end
      end
      C_SGR: begin
        cmd.op = OP_SGR_STEP;
        if (stat.sgr_last) begin
          state_next = C_IDLE;
        end
      end
      C_ERASE: begin
        if (stat.out_free) begin
          cmd.op     = OP_ERASE;
          state_next = C_IDLE;
        end
      end
      C_SCROLL: begin
        if (stat.out_free) begin
          cmd.op     = OP_SCROLL;
          state_next = C_IDLE;
        end
      end
      default: begin
        state_next = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      parse    <= P_NORMAL;
      s_tready <= 1'b1;
    end else begin
      state    <= state_next;
      parse    <= parse_next;
      s_tready <= (state_next == C_IDLE);
    end
  end

endmodule

>>> src/atcp_dp.sv
// Datapath: config, parameters, cursor, colors and the result register.
`timescale 1ns / 1ps

module atcp_dp #(
  parameter int unsigned MAX_PARAMS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [7:0]                          s_tdata,
  input  logic                                cfg_we,
  input  logic [atcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [atcp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  atcp_pkg::dp_cmd_t                   cmd,
  output atcp_pkg::dp_stat_t                  stat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [atcp_pkg::OUT_W-1:0]          m_tdata,
  output logic                                m_tlast
);
  import atcp_pkg::*;

  localparam int unsigned CW     = $clog2(MAX_PARAMS + 1);
  localparam int unsigned IW     = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam bit          HAS_P1 = (MAX_PARAMS >= 2);
  localparam int unsigned P1_IDX = HAS_P1 ? 1 : 0;

  logic          enabled;
  logic [7:0]    num_columns;
  logic [7:0]    num_rows;
  logic [7:0]    char_reg;
  logic [15:0]   param_values [MAX_PARAMS];
  logic [CW-1:0] param_count;
  logic [15:0]   current_param;
  logic [IW-1:0] sgr_idx;
  logic [7:0]    cursor_column;
  logic [7:0]    cursor_line;
  logic [3:0]    foreground;
  logic [2:0]    background;

  logic [7:0]  cols_m1, rows_m1;
  logic [8:0]  col_inc, line_inc;
  logic        wrap, line_over;
  logic [7:0]  line_nl;
  logic [15:0] p0, p1, sgr_p;
  logic [19:0] digit_sum;
  logic [15:0] digit_sat;
  logic        can_store;
  logic [15:0] row16, col16, n16;
  logic [7:0]  cup_row, cup_col, up_line, down_line;
  logic [16:0] down_sum;

  logic        emit, emit_last;
  logic [1:0]  emit_cmd;
  logic [7:0]  emit_col, emit_line, emit_glyph;

  assign cols_m1   = (num_columns == 8'd0) ? 8'd0 : num_columns - 8'd1;
  assign rows_m1   = (num_rows == 8'd0) ? 8'd0 : num_rows - 8'd1;
  assign col_inc   = {1'b0, cursor_column} + 9'd1;
  assign line_inc  = {1'b0, cursor_line} + 9'd1;
  assign wrap      = col_inc > {1'b0, cols_m1};
  assign line_over = line_inc > {1'b0, rows_m1};
  assign line_nl   = line_over ? rows_m1 : line_inc[7:0];

  assign p0    = param_values[0];
  assign p1    = param_values[P1_IDX];
  assign sgr_p = param_values[sgr_idx];

  // current_param * 10 + digit, saturating
  assign digit_sum = {1'b0, current_param, 3'b000} + {3'b000, current_param, 1'b0}
                   + {16'd0, char_reg[3:0]};
  assign digit_sat = (digit_sum > 20'd65535) ? 16'hFFFF : digit_sum[15:0];
  assign can_store = param_count < CW'(MAX_PARAMS);

  assign row16   = (p0 == 16'd0) ? 16'd0 : p0 - 16'd1;
  assign col16   = (HAS_P1 && param_count >= CW'(2) && p1 != 16'd0) ? p1 - 16'd1 : 16'd0;
  assign cup_row = (row16 > {8'd0, rows_m1}) ? rows_m1 : row16[7:0];
  assign cup_col = (col16 > {8'd0, cols_m1}) ? cols_m1 : col16[7:0];

  assign n16       = (p0 == 16'd0) ? 16'd1 : p0;
  assign up_line   = (n16 >= {8'd0, cursor_line}) ? 8'd0 : cursor_line - n16[7:0];
  assign down_sum  = {1'b0, n16} + {9'd0, cursor_line};
  assign down_line = (down_sum > {9'd0, rows_m1}) ? rows_m1 : down_sum[7:0];

  assign stat.char_code   = char_reg;
  assign stat.enabled     = enabled;
  assign stat.out_free    = !m_tvalid || m_tready;
  assign stat.draw_scroll = wrap && line_over;
  assign stat.p0_is2      = (p0 == 16'd2);
  assign stat.sgr_last    = (CW'(sgr_idx) + CW'(1)) >= param_count;

  always_comb begin
    emit       = 1'b0;
    emit_cmd   = CMD_SCROLL;
    emit_col   = 8'd0;
    emit_line  = 8'd0;
    emit_glyph = 8'd0;
    emit_last  = 1'b1;
    unique case (cmd.op)
      OP_LF: begin
        emit = line_over;
      end
      OP_DRAW: begin
        emit       = 1'b1;
        emit_cmd   = CMD_DRAW;
        emit_col   = cursor_column;
        emit_line  = cursor_line;
        emit_glyph = char_reg;
        emit_last  = !(wrap && line_over);
      end
      OP_ERASE: begin
        emit      = 1'b1;
        emit_cmd  = CMD_ERASE;
        emit_col  = cursor_column;
        emit_line = cursor_line;
      end
      OP_SCROLL: begin
        emit = 1'b1;
      end
      OP_CLEAR: begin
        emit     = 1'b1;
        emit_cmd = CMD_CLEAR;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled       <= 1'b1;
      num_columns   <= 8'd80;
      num_rows      <= 8'd25;
      param_count   <= '0;
      current_param <= 16'd0;
      sgr_idx       <= '0;
      cursor_column <= 8'd0;
      cursor_line   <= 8'd0;
      foreground    <= FG_DEFAULT;
      background    <= BG_DEFAULT;
      m_tvalid      <= 1'b0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        param_values[i] <= 16'd0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLED:     enabled     <= cfg_data[0];
          REG_NUM_COLUMNS: num_columns <= cfg_data;
          REG_NUM_ROWS:    num_rows    <= cfg_data;
          default: ;
        endcase
      end

      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (cmd.op)
        OP_CR: begin
          cursor_column <= 8'd0;
        end
        OP_LF: begin
          cursor_column <= 8'd0;
          cursor_line   <= line_nl;
        end
        OP_BS: begin
          if (cursor_column != 8'd0) begin
            cursor_column <= cursor_column - 8'd1;
          end else if (cursor_line != 8'd0) begin
            cursor_line   <= cursor_line - 8'd1;
            cursor_column <= cols_m1;
          end
        end
        OP_DRAW: begin
          if (wrap) begin
            cursor_column <= 8'd0;
            cursor_line   <= line_nl;
          end else begin
            cursor_column <= col_inc[7:0];
          end
        end
        OP_ESC_CLR: begin
          param_count   <= '0;
          current_param <= 16'd0;
          sgr_idx       <= '0;
          for (int i = 0; i < MAX_PARAMS; i++) begin
            param_values[i] <= 16'd0;
          end
        end
        OP_DIGIT: begin
          current_param <= digit_sat;
        end
        OP_SEMI: begin
          if (can_store) begin
            param_values[param_count[IW-1:0]] <= current_param;
            param_count <= param_count + CW'(1);
          end
          current_param <= 16'd0;
        end
        OP_SGR_STEP: begin
          sgr_idx <= IW'(sgr_idx + 1'b1);
          priority if (sgr_p == 16'd0) begin
            foreground <= FG_DEFAULT;
            background <= BG_DEFAULT;
          end else if (sgr_p >= 16'd30 && sgr_p <= 16'd37) begin
            foreground <= 4'(sgr_p - 16'd30);
          end else if (sgr_p >= 16'd40 && sgr_p <= 16'd47) begin
            background <= 3'(sgr_p - 16'd40);
          end else if (sgr_p == 16'd90) begin
            foreground <= FG_GRAY;
          end else if (sgr_p == 16'd97) begin
            foreground <= FG_DEFAULT;
          end
        end
        OP_CLEAR: begin
          cursor_column <= 8'd0;
          cursor_line   <= 8'd0;
        end
        OP_CUP: begin
          cursor_column <= cup_col;
          cursor_line   <= cup_row;
        end
        OP_CUU: begin
          cursor_line <= up_line;
        end
        OP_CUD: begin
          cursor_line <= down_line;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_reg <= s_tdata;
    end
    if (emit) begin
      m_tdata <= {7'd0, background, foreground, emit_glyph, emit_line, emit_col, emit_cmd};
      m_tlast <= emit_last;
    end
  end

endmodule

>>> src/atcp_chk.sv
// Port-level assertion checker for the ANSI text console parser, with bind.
`timescale 1ns / 1ps

module atcp_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [atcp_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tlast
);
  import atcp_pkg::*;

  logic [1:0] res_cmd;
  logic [3:0] res_fg;

  assign res_cmd = m_tdata[1:0];
  assign res_fg  = m_tdata[29:26];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // one byte in flight
  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second byte accepted while busy");

  // only a draw can be followed by another command of the same byte
  a_nonlast_draw: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> res_cmd == CMD_DRAW)
    else $error("non-final result is not a draw");

  // scroll and clear carry no cell; non-draw carries no glyph
  a_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res_cmd != CMD_DRAW |->
      m_tdata[25:18] == 8'd0 &&
      (res_cmd == CMD_ERASE || m_tdata[17:2] == 16'd0))
    else $error("unused result fields not zero");

  a_fg_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res_fg <= FG_GRAY)
    else $error("foreground index out of range");

endmodule

bind ansi_text_console_parser atcp_chk u_atcp_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> tb/atcp_tb_pkg.sv
// Character and escape-code constants shared by the console parser testbench.
`timescale 1ns / 1ps

package atcp_tb_pkg;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CSI   = "[";
  localparam logic [7:0] CH_SEP   = ";";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";

  localparam logic [7:0] FIN_SGR = "m";
  localparam logic [7:0] FIN_ED  = "J";
  localparam logic [7:0] FIN_CUP = "H";
  localparam logic [7:0] FIN_HVP = "f";
  localparam logic [7:0] FIN_CUU = "A";
  localparam logic [7:0] FIN_CUD = "B";

  localparam int unsigned SGR_RESET     = 0;
  localparam int unsigned SGR_FG_FIRST  = 30;
  localparam int unsigned SGR_FG_LAST   = 37;
  localparam int unsigned SGR_BG_FIRST  = 40;
  localparam int unsigned SGR_BG_LAST   = 47;
  localparam int unsigned SGR_FG_GRAY   = 90;
  localparam int unsigned SGR_FG_WHITE  = 97;
  localparam int unsigned ED_ALL        = 2;
  localparam int unsigned PARAM_MAX     = 65535;

  localparam logic [7:0] COLS_AT_RESET = 8'd80;
  localparam logic [7:0] ROWS_AT_RESET = 8'd25;

endpackage

>>> tb/atcp_command_monitor.sv
// Console parser monitor: predicts display commands per input byte and compares them.
`timescale 1ns / 1ps

module atcp_command_monitor #(
  parameter int unsigned MAX_PARAMS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [7:0]                      s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [atcp_pkg::OUT_W-1:0]      m_tdata,
  input  logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [atcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atcp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import atcp_pkg::*;
  import atcp_tb_pkg::*;

  typedef enum logic [1:0] {PS_NORMAL, PS_ESC, PS_BRACKET, PS_PARAM} parse_mode_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] glyph;
    logic [3:0] fg;
    logic [2:0] bg;
    logic       is_last;
  } disp_cmd_t;

  parse_mode_t  mode;
  logic         en;
  logic [7:0]   cols;
  logic [7:0]   rows;
  int unsigned  params [MAX_PARAMS];
  int unsigned  nparams;
  int unsigned  acc;
  int unsigned  cur_col;
  int unsigned  cur_row;
  logic [3:0]   fg_color;
  logic [2:0]   bg_color;

  disp_cmd_t    cmd_q [$];
  disp_cmd_t    burst [2];
  int           burst_n;

  function automatic int unsigned line_len();
    return (cols == 8'd0) ? 32'd1 : 32'(cols);
  endfunction

  function automatic int unsigned screen_h();
    return (rows == 8'd0) ? 32'd1 : 32'(rows);
  endfunction

  task automatic emit(logic [1:0] op, int unsigned col, int unsigned row, logic [7:0] g);
    disp_cmd_t c;
    c.cmd     = op;
    c.col     = col[7:0];
    c.row     = row[7:0];
    c.glyph   = g;
    c.fg      = fg_color;
    c.bg      = bg_color;
    c.is_last = 1'b0;
    burst[burst_n] = c;
    burst_n++;
  endtask

  task automatic new_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= screen_h()) begin
      emit(CMD_SCROLL, 0, 0, 8'd0);
      cur_row = screen_h() - 1;
    end
  endtask

  task automatic apply_sgr();
    int unsigned p;
    for (int unsigned i = 0; i < nparams && i < MAX_PARAMS; i++) begin
      p = params[i];
      if (p == SGR_RESET) begin
        fg_color = FG_DEFAULT;
        bg_color = BG_DEFAULT;
      end else if (p >= SGR_FG_FIRST && p <= SGR_FG_LAST) begin
        fg_color = 4'(p - SGR_FG_FIRST);
      end else if (p >= SGR_BG_FIRST && p <= SGR_BG_LAST) begin
        bg_color = 3'(p - SGR_BG_FIRST);
      end else if (p == SGR_FG_GRAY) begin
        fg_color = FG_GRAY;
      end else if (p == SGR_FG_WHITE) begin
        fg_color = FG_DEFAULT;
      end
    end
  endtask

  task automatic end_sequence(logic [7:0] c);
    int unsigned p0;
    int unsigned r;
    int unsigned k;
    int unsigned n;
    if (nparams < MAX_PARAMS) begin
      params[nparams] = acc;
      nparams++;
    end
    acc = 0;
    p0 = params[0];
    n = (p0 > 0) ? p0 : 1;
    case (c)
      FIN_SGR: apply_sgr();
      FIN_ED: begin
        if (p0 == ED_ALL) begin
          cur_col = 0;
          cur_row = 0;
          emit(CMD_CLEAR, 0, 0, 8'd0);
        end
      end
      FIN_CUP, FIN_HVP: begin
        r = (p0 > 0) ? p0 - 1 : 0;
        k = (nparams >= 2 && params[1] > 0) ? params[1] - 1 : 0;
        if (r >= screen_h()) r = screen_h() - 1;
        if (k >= line_len()) k = line_len() - 1;
        cur_col = k;
        cur_row = r;
      end
      FIN_CUU: cur_row = (n >= cur_row) ? 0 : cur_row - n;
      FIN_CUD: begin
        r = cur_row + n;
        if (r >= screen_h()) r = screen_h() - 1;
        cur_row = r;
      end
      default: ;
    endcase
    mode = PS_NORMAL;
  endtask

  task automatic predict_byte(logic [7:0] c);
    int unsigned v;
    burst_n = 0;
    if (en) begin
      case (mode)
        PS_NORMAL: begin
          if (c == CH_ESC) begin
            mode = PS_ESC;
          end else if (c == CH_CR) begin
            cur_col = 0;
          end else if (c == CH_LF) begin
            new_line();
          end else if (c == CH_BS || c == CH_DEL) begin
            if (cur_col > 0) begin
              cur_col--;
            end else if (cur_row > 0) begin
              cur_row--;
              cur_col = line_len() - 1;
            end
            emit(CMD_ERASE, cur_col, cur_row, 8'd0);
          end else if (c >= CH_SPACE && c <= CH_TILDE) begin
            emit(CMD_DRAW, cur_col, cur_row, c);
            cur_col++;
            if (cur_col >= line_len()) new_line();
          end
        end
        PS_ESC: begin
          if (c == CH_CSI) begin
            mode = PS_BRACKET;
            nparams = 0;
            acc = 0;
            foreach (params[j]) params[j] = 0;
          end else begin
            mode = PS_NORMAL;
          end
        end
        default: begin
          mode = PS_PARAM;
          if (c >= CH_ZERO && c <= CH_NINE) begin
            v = acc * 10 + 32'(c - CH_ZERO);
            acc = (v > PARAM_MAX) ? PARAM_MAX : v;
          end else if (c == CH_SEP) begin
            if (nparams < MAX_PARAMS) begin
              params[nparams] = acc;
              nparams++;
            end
            acc = 0;
          end else begin
            end_sequence(c);
          end
        end
      endcase
    end
    for (int i = 0; i < burst_n; i++) begin
      if (i == burst_n - 1) burst[i].is_last = 1'b1;
      cmd_q.push_back(burst[i]);
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    disp_cmd_t want;
    if (rst) begin
      mode        = PS_NORMAL;
      en          = 1'b1;
      cols        = COLS_AT_RESET;
      rows        = ROWS_AT_RESET;
      foreach (params[j]) params[j] = 0;
      nparams     = 0;
      acc         = 0;
      cur_col     = 0;
      cur_row     = 0;
      fg_color    = FG_DEFAULT;
      bg_color    = BG_DEFAULT;
      cmd_q.delete();
      mismatches  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (cmd_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected command transaction, expected none actual %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = cmd_q.pop_front();
          check_field("command", 16'(want.cmd), 16'(m_tdata[1:0]));
          check_field("column", 16'(want.col), 16'(m_tdata[9:2]));
          check_field("line", 16'(want.row), 16'(m_tdata[17:10]));
          check_field("glyph", 16'(want.glyph), 16'(m_tdata[25:18]));
          check_field("fg_index", 16'(want.fg), 16'(m_tdata[29:26]));
          check_field("bg_index", 16'(want.bg), 16'(m_tdata[32:30]));
          check_field("padding", 16'd0, 16'(m_tdata[39:33]));
          check_field("last", 16'(want.is_last), 16'(m_tlast));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLED:     en = cfg_data[0];
          REG_NUM_COLUMNS: cols = cfg_data;
          REG_NUM_ROWS:    rows = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_byte(s_tdata);
    end
    outstanding = cmd_q.size();
  end

endmodule

>>> tb/ansi_text_console_parser_tb.sv
// Console parser testbench top: clock, reset, byte stimulus, register writes and verdict.
`timescale 1ns / 1ps

module ansi_text_console_parser_tb;
  import atcp_pkg::*;
  import atcp_tb_pkg::*;

  localparam int unsigned MAX_PARAMS = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int sent = 0;
  bit idle_en = 1'b1;
  bit stall_en = 1'b1;

  always #5 clk = ~clk;

  ansi_text_console_parser #(.MAX_PARAMS(MAX_PARAMS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  atcp_command_monitor #(.MAX_PARAMS(MAX_PARAMS)) cmd_mon (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always @(posedge clk) m_tready <= stall_en ? ($urandom_range(0, 99) >= 33) : 1'b1;

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // valid stays high between back-to-back transactions; it drops only on a gap
  task automatic put_byte(logic [7:0] b);
    if (idle_en) begin
      while ($urandom_range(0, 99) < 33) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic put_number(int unsigned v);
    logic [7:0] digs [10];
    int n;
    n = 0;
    do begin
      digs[n] = CH_ZERO + 8'(v % 10);
      v = v / 10;
      n++;
    end while (v != 0);
    for (int i = n - 1; i >= 0; i--) put_byte(digs[i]);
  endtask

  task automatic put_param(logic [7:0] fin, bit first);
    int r;
    r = $urandom_range(0, 9);
    if (fin == FIN_ED && first && r < 7) begin
      put_number(ED_ALL);
    end else begin
      case (r)
        0: put_number(0);
        1: put_number($urandom_range(1, 3));
        2, 3, 4: begin
          case ($urandom_range(0, 4))
            0: put_number($urandom_range(SGR_FG_FIRST, SGR_FG_LAST));
            1: put_number($urandom_range(SGR_BG_FIRST, SGR_BG_LAST));
            2: put_number(SGR_FG_GRAY);
            3: put_number(SGR_FG_WHITE);
            default: put_number($urandom_range(1, 120));
          endcase
        end
        5, 6: put_number($urandom_range(1, 300));
        7: put_number($urandom_range(256, PARAM_MAX));
        // long digit run, may saturate
        8: repeat ($urandom_range(6, 8)) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        default: ;
      endcase
    end
  endtask

  task automatic put_csi();
    int np;
    logic [7:0] fin;
    case ($urandom_range(0, 9))
      0, 1, 2: fin = FIN_SGR;
      3: fin = FIN_ED;
      4: fin = FIN_CUP;
      5: fin = FIN_HVP;
      6: fin = FIN_CUU;
      7: fin = FIN_CUD;
      default: fin = 8'($urandom_range(8'h40, 8'h7E));
    endcase
    np = ($urandom_range(0, 9) == 0) ? $urandom_range(4, MAX_PARAMS + 3) : $urandom_range(0, 3);
    put_byte(CH_ESC);
    put_byte(CH_CSI);
    for (int i = 0; i < np; i++) begin
      if (i > 0) put_byte(CH_SEP);
      put_param(fin, i == 0);
    end
    put_byte(fin);
  endtask

  task automatic put_sequence();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
    end else if (kind < 50) begin
      case ($urandom_range(0, 3))
        0: put_byte(CH_CR);
        1: put_byte(CH_LF);
        2: put_byte(CH_BS);
        default: put_byte(CH_DEL);
      endcase
    end else if (kind < 85) begin
      put_csi();
    end else begin
      case ($urandom_range(0, 3))
        0: put_byte(8'($urandom_range(0, 255)));
        1: begin
          put_byte(CH_ESC);
          put_byte(8'($urandom_range(0, 255)));
        end
        2: begin
          // sequence cut short by a control, ESC or high byte
          put_byte(CH_ESC);
          put_byte(CH_CSI);
          put_number($urandom_range(0, 99));
          case ($urandom_range(0, 2))
            0: put_byte(8'($urandom_range(0, 31)));
            1: put_byte(8'($urandom_range(128, 255)));
            default: put_byte(CH_ESC);
          endcase
        end
        default: put_byte(8'($urandom_range(0, 31)));
      endcase
    end
  endtask

  task automatic run_random(int n);
    int stop;
    stop = sent + n;
    while (sent < stop) put_sequence();
  endtask

  // sender holds off until every predicted command is out and the block is quiet
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [7:0] opening [$] = '{
      "A", CH_SPACE, CH_TILDE, CH_DEL, CH_BS, CH_CR, CH_LF, 8'h00, 8'hFF,
      CH_ESC, "x", CH_ESC, CH_CSI, "2", FIN_ED, CH_BS,
      CH_ESC, CH_CSI, "9", "0", CH_SEP, "4", "7", FIN_SGR, "Z"
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) put_byte(opening[i]);
    run_random(200);

    write_reg(REG_NUM_COLUMNS, 8'd255);
    write_reg(REG_NUM_ROWS, 8'd255);
    run_random(150);

    // zero size acts as one cell
    write_reg(REG_NUM_COLUMNS, 8'd0);
    write_reg(REG_NUM_ROWS, 8'd0);
    run_random(100);

    write_reg(REG_NUM_COLUMNS, 8'd1);
    write_reg(REG_NUM_ROWS, 8'd255);
    run_random(100);

    // tiny console, full rate on both sides
    write_reg(REG_NUM_COLUMNS, 8'd7);
    write_reg(REG_NUM_ROWS, 8'd3);
    idle_en  = 1'b0;
    stall_en = 1'b0;
    run_random(200);
    idle_en  = 1'b1;
    stall_en = 1'b1;

    // park the cursor far out, then shrink the console under it
    write_reg(REG_NUM_COLUMNS, COLS_AT_RESET);
    write_reg(REG_NUM_ROWS, ROWS_AT_RESET);
    put_byte(CH_ESC);
    put_byte(CH_CSI);
    put_number(20);
    put_byte(CH_SEP);
    put_number(70);
    put_byte(FIN_CUP);
    write_reg(REG_NUM_COLUMNS, 8'd10);
    write_reg(REG_NUM_ROWS, 8'd4);
    put_byte("q");
    put_byte(CH_BS);
    run_random(150);

    write_reg(REG_ENABLED, 8'd0);
    repeat (15) put_sequence();
    write_reg(REG_ENABLED, 8'd1);
    write_reg(REG_NUM_COLUMNS, 8'd255);
    write_reg(REG_NUM_ROWS, 8'd1);
    run_random(100);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
